// File: hdl/indexed_linked_list_engine_assert.svh
// assertion macros used by the checker file of the linked list engine
// depends on: nothing; expects clk_i and rst_ni in the scope that uses them
`ifndef INDEXED_LINKED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LINKED_LIST_ENGINE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define ILE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ile_pkg.sv
// types and constants of the indexed linked list engine
// depends on: nothing
`timescale 1ns / 1ps

package ile_pkg;

  localparam int POS_W  = 11;
  localparam int TYPE_W = 3;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 11;

  typedef enum logic [TYPE_W-1:0] {
    REQ_GET    = 3'd0,
    REQ_SET    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_APPEND = 3'd3,
    REQ_REMOVE = 3'd4,
    REQ_SEARCH = 3'd5
  } ile_req_e;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_REM1,
    ST_REM2,
    ST_REM3,
    ST_INS_RD,
    ST_INS1,
    ST_INS2,
    ST_INS3,
    ST_FINISH
  } ile_state_e;

endpackage

// File: hdl/ile_ram.sv
// generic single write, single read ram with registered read data
// depends on: nothing
`timescale 1ns / 1ps

module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/indexed_linked_list_engine.sv
// get, set and search walk the list; remove then unlinks the node and pushes it on
// the free chain; insert walks to its position unless at the end, then pops a free
// node and links it in; append pops one with no walk; rejected or unknown items finish
// throughput: one item at a time; the walk follows the next-link memory at one
// node per cycle, and a stalled output holds the result before the next item
// reset: a clearing pass links all nodes into the free chain; no item is accepted
// until it ends
`timescale 1ns / 1ps

module indexed_linked_list_engine
  import ile_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // position, value
  input  logic [((POS_W+DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // req_type
  input  logic [TYPE_W-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // data, found_position, status, count
  output logic [((DATA_WIDTH+POS_W+STAT_W+CNT_W+7)/8)*8-1:0] m_axis_tdata
);

  localparam int LW    = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int CMPW  = (LW > POS_W) ? LW : POS_W;
  localparam int OUT_W = ((DATA_WIDTH + POS_W + STAT_W + CNT_W + 7) / 8) * 8;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  ile_state_e state_q, state_d;

  logic [AW-1:0]         init_q, init_d;
  logic [LW-1:0]         head_q, head_d, tail_q, tail_d, fh_q, fh_d, count_q, count_d;
  logic [LW-1:0]         cur_q, cur_d, succ_q, succ_d, pred_q, pred_d;
  logic [LW-1:0]         nx_q, nx_d, nn_q, nn_d;
  logic [CMPW-1:0]       idx_q, idx_d;
  ile_req_e              req_q, req_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d, data_q, data_d;
  logic [POS_W-1:0]      found_q, found_d;
  logic [STAT_W-1:0]     status_q, status_d;
  logic                  mv_q, mv_d;
  logic [OUT_W-1:0]      mdata_q, mdata_d;

  // memory ports
  logic                  v_we, n_we, p_we;
  logic [LW-1:0]         v_waddr, n_waddr, p_waddr, raddr;
  logic [DATA_WIDTH-1:0] v_wdata, v_rd;
  logic [LW-1:0]         n_wdata, p_wdata, n_rd, p_rd;

  // input decode
  ile_req_e              in_type;
  logic [POS_W-1:0]      in_pos;
  logic [DATA_WIDTH-1:0] in_val;
  logic                  accept;
  logic [CMPW-1:0]       in_pos_ext, count_ext;
  logic                  range_err, full_err, at_end;
  logic                  walk_stop;

  assign in_type    = ile_req_e'(s_axis_tuser);
  assign in_pos     = s_axis_tdata[POS_W-1:0];
  assign in_val     = s_axis_tdata[POS_W +: DATA_WIDTH];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign in_pos_ext = CMPW'(in_pos);
  assign count_ext  = CMPW'(count_q);
  assign at_end     = (in_pos_ext == count_ext);

  // request checks at acceptance
  always_comb begin
    range_err = 1'b0;
    full_err  = 1'b0;
    case (in_type)
      REQ_GET, REQ_SET, REQ_REMOVE: range_err = (in_pos_ext >= count_ext);
      REQ_INSERT: begin
        range_err = (in_pos_ext > count_ext);
        full_err  = (count_q == NIL) || (fh_q == NIL);
      end
      REQ_APPEND: full_err = (count_q == NIL) || (fh_q == NIL);
      default: begin
        range_err = 1'b0;
        full_err  = 1'b0;
      end
    endcase
  end

  // walk ends on a null node or on the target node
  always_comb begin
    if (cur_q == NIL) begin
      walk_stop = 1'b1;
    end else if (req_q == REQ_SEARCH) begin
      walk_stop = (v_rd == val_q);
    end else begin
      walk_stop = (idx_q == CMPW'(pos_q));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: if (init_q == AW'(CAPACITY - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (in_type)
            REQ_GET, REQ_SET, REQ_REMOVE: state_d = range_err ? ST_FINISH : ST_WALK;
            REQ_INSERT: begin
              if (range_err || full_err) state_d = ST_FINISH;
              else if (at_end)           state_d = ST_INS_RD;
              else                       state_d = ST_WALK;
            end
            REQ_APPEND: state_d = full_err ? ST_FINISH : ST_INS_RD;
            REQ_SEARCH: state_d = ST_WALK;
            default:    state_d = ST_FINISH;
          endcase
        end
      end
      ST_WALK: begin
        if (walk_stop) begin
          if (cur_q == NIL)              state_d = ST_FINISH;
          else if (req_q == REQ_REMOVE)  state_d = ST_REM1;
          else if (req_q == REQ_INSERT)  state_d = ST_INS_RD;
          else                           state_d = ST_FINISH;
        end
      end
      ST_REM1:   state_d = ST_REM2;
      ST_REM2:   state_d = ST_REM3;
      ST_REM3:   state_d = ST_FINISH;
      ST_INS_RD: state_d = ST_INS1;
      ST_INS1:   state_d = ST_INS2;
      ST_INS2:   state_d = ST_INS3;
      ST_INS3:   state_d = ST_FINISH;
      ST_FINISH: if (!mv_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    init_d   = init_q;
    head_d   = head_q;
    tail_d   = tail_q;
    fh_d     = fh_q;
    count_d  = count_q;
    cur_d    = cur_q;
    succ_d   = succ_q;
    pred_d   = pred_q;
    nx_d     = nx_q;
    nn_d     = nn_q;
    idx_d    = idx_q;
    req_d    = req_q;
    pos_d    = pos_q;
    val_d    = val_q;
    data_d   = data_q;
    found_d  = found_q;
    status_d = status_q;
    mv_d     = mv_q && !m_axis_tready;
    mdata_d  = mdata_q;
    v_we     = 1'b0;
    n_we     = 1'b0;
    p_we     = 1'b0;
    v_waddr  = cur_q;
    n_waddr  = nn_q;
    p_waddr  = nn_q;
    v_wdata  = val_q;
    n_wdata  = NIL;
    p_wdata  = NIL;
    raddr    = cur_q;
    case (state_q)
      // link every node to its neighbors
      ST_INIT: begin
        n_we    = 1'b1;
        p_we    = 1'b1;
        n_waddr = LW'(init_q);
        p_waddr = LW'(init_q);
        n_wdata = LW'(init_q) + LW'(1);
        p_wdata = (init_q == '0) ? NIL : LW'(init_q) - LW'(1);
        init_d  = init_q + AW'(1);
      end
      ST_IDLE: begin
        raddr = head_q;
        if (accept) begin
          req_d    = in_type;
          pos_d    = in_pos;
          val_d    = in_val;
          cur_d    = head_q;
          idx_d    = '0;
          data_d   = '0;
          found_d  = '1;
          succ_d   = NIL;
          pred_d   = tail_q;
          if (range_err)     status_d = STAT_RANGE;
          else if (full_err) status_d = STAT_FULL;
          else               status_d = STAT_OK;
        end
      end
      // follow the chain one node per cycle
      ST_WALK: begin
        if (!walk_stop) begin
          cur_d = n_rd;
          idx_d = idx_q + CMPW'(1);
          raddr = n_rd;
        end else if (cur_q == NIL) begin
          status_d = (req_q == REQ_SEARCH) ? STAT_NOT_FOUND : STAT_RANGE;
        end else begin
          case (req_q)
            REQ_SEARCH: found_d = idx_q[POS_W-1:0];
            REQ_GET:    data_d  = v_rd;
            REQ_SET: begin
              data_d = v_rd;
              v_we   = 1'b1;
            end
            REQ_REMOVE: begin
              data_d = v_rd;
              nx_d   = n_rd;
              pred_d = p_rd;
              nn_d   = cur_q;
            end
            REQ_INSERT: begin
              succ_d = cur_q;
              pred_d = p_rd;
            end
            default: data_d = data_q;
          endcase
        end
      end
      // unlink the node from its neighbors
      ST_REM1: begin
        if (pred_q != NIL) begin
          n_we    = 1'b1;
          n_waddr = pred_q;
          n_wdata = nx_q;
        end else begin
          head_d = nx_q;
        end
        if (nx_q != NIL) begin
          p_we    = 1'b1;
          p_waddr = nx_q;
          p_wdata = pred_q;
        end else begin
          tail_d = pred_q;
        end
      end
      // push the node on the free chain
      ST_REM2: begin
        n_we    = 1'b1;
        n_wdata = fh_q;
        p_we    = 1'b1;
        p_wdata = NIL;
      end
      ST_REM3: begin
        if (fh_q != NIL) begin
          p_we    = 1'b1;
          p_waddr = fh_q;
          p_wdata = nn_q;
        end
        fh_d    = nn_q;
        count_d = count_q - LW'(1);
      end
      // pop a node from the free chain
      ST_INS_RD: begin
        raddr = fh_q;
        nn_d  = fh_q;
      end
      ST_INS1: begin
        fh_d    = n_rd;
        v_we    = 1'b1;
        v_waddr = nn_q;
        n_we    = 1'b1;
        n_wdata = succ_q;
        p_we    = 1'b1;
        p_wdata = pred_q;
      end
      ST_INS2: begin
        if (fh_q != NIL) begin
          p_we    = 1'b1;
          p_waddr = fh_q;
          p_wdata = NIL;
        end
        if (pred_q != NIL) begin
          n_we    = 1'b1;
          n_waddr = pred_q;
          n_wdata = nn_q;
        end else begin
          head_d = nn_q;
        end
      end
      ST_INS3: begin
        if (succ_q != NIL) begin
          p_we    = 1'b1;
          p_waddr = succ_q;
          p_wdata = nn_q;
        end else begin
          tail_d = nn_q;
        end
        count_d = count_q + LW'(1);
      end
      // hand the result to the output register
      ST_FINISH: begin
        if (!mv_q || m_axis_tready) begin
          mv_d    = 1'b1;
          mdata_d = OUT_W'({count_ext[CNT_W-1:0], status_q, found_q, data_q});
        end
      end
      default: mv_d = mv_q && !m_axis_tready;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      init_q  <= '0;
      head_q  <= NIL;
      tail_q  <= NIL;
      fh_q    <= '0;
      count_q <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fh_q    <= fh_d;
      count_q <= count_d;
      mv_q    <= mv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    succ_q   <= succ_d;
    pred_q   <= pred_d;
    nx_q     <= nx_d;
    nn_q     <= nn_d;
    idx_q    <= idx_d;
    req_q    <= req_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    data_q   <= data_d;
    found_q  <= found_d;
    status_q <= status_d;
    mdata_q  <= mdata_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mdata_q;

  // node store
  ile_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr[AW-1:0]),
    .wdata_i (v_wdata),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (v_rd)
  );

  ile_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr[AW-1:0]),
    .wdata_i (n_wdata),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (n_rd)
  );

  ile_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr[AW-1:0]),
    .wdata_i (p_wdata),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (p_rd)
  );

endmodule

// File: hdl/ile_checker.sv
// port level checks of the indexed linked list engine, bound to the top level
// depends on: ile_pkg, indexed_linked_list_engine_assert.svh
`timescale 1ns / 1ps
`include "indexed_linked_list_engine_assert.svh"

module ile_checker
  import ile_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input logic clk_i,
  input logic rst_ni,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  // data, found_position, status, count
  input logic [((DATA_WIDTH+POS_W+STAT_W+CNT_W+7)/8)*8-1:0] m_axis_tdata
);

  logic [DATA_WIDTH-1:0] res_data;
  logic [POS_W-1:0]      res_found;
  logic [STAT_W-1:0]     res_status;
  logic [CNT_W-1:0]      res_count;

  assign res_data   = m_axis_tdata[DATA_WIDTH-1:0];
  assign res_found  = m_axis_tdata[DATA_WIDTH +: POS_W];
  assign res_status = m_axis_tdata[DATA_WIDTH+POS_W +: STAT_W];
  assign res_count  = m_axis_tdata[DATA_WIDTH+POS_W+STAT_W +: CNT_W];

  // a stalled result holds
  `ILE_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  // a missing key reports no position
  `ILE_ASSERT_SAME(a_notfound, m_axis_tvalid && (res_status == STAT_NOT_FOUND), res_found == '1, "not found with a position")
  // a found position comes only with ok status
  `ILE_ASSERT_SAME(a_found_ok, m_axis_tvalid && (res_found != '1), res_status == STAT_OK, "position with error status")
  // a bad position returns no data
  `ILE_ASSERT_SAME(a_range_zero, m_axis_tvalid && (res_status == STAT_RANGE), res_data == '0, "data on range error")
  // count never exceeds the store
  `ILE_ASSERT_SAME(a_count, m_axis_tvalid, 32'(res_count) <= 32'(CAPACITY), "count beyond capacity")

endmodule

bind indexed_linked_list_engine ile_checker #(
  .CAPACITY   (CAPACITY),
  .DATA_WIDTH (DATA_WIDTH)
) u_ile_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
